FILE: src/oal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oal_pkg;

   // Default sizing of the list store.
   localparam int DEPTH_DEF      = 64;
   localparam int WORD_WIDTH_DEF = 32;

   // Fixed widths of the port fields.
   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 7;
   localparam int IO_WORD_W  = 32;
   localparam int STATUS_W   = 2;
   localparam int FOUND_W    = 6;
   localparam int LENGTH_W   = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 3'd0,
      ACT_APPEND = 3'd1,
      ACT_DELETE = 3'd2,
      ACT_READ   = 3'd3,
      ACT_FIND   = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_INDEX = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_HOLD
   } seq_state_type;

   // Result fields that do not depend on the word width.
   typedef struct packed {
      status_type          status;
      logic [FOUND_W-1:0]  found_at;
      logic [LENGTH_W-1:0] list_length;
   } rsp_meta_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic idle;
      logic hold;
   } seq_flags_type;

endpackage

`default_nettype wire

FILE: src/oal_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port-write, single-port-read list memory with a registered read.
module oal_store #(
   parameter int DEPTH      = oal_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WORD_WIDTH-1:0]    rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WORD_WIDTH-1:0]    wr_data
);

   logic [WORD_WIDTH-1:0] list_mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= list_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/oal_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer: checks each request, then walks the memory one read and
// one write-back per cycle to shift, fetch or search entries.
module oal_seq #(
   parameter int DEPTH      = oal_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic [oal_pkg::ACTION_W-1:0]      req_action,
   input  wire logic [oal_pkg::POSITION_W-1:0]    req_position,
   input  wire logic [WORD_WIDTH-1:0]             req_word,
   input  wire logic                              slot_free,
   output      oal_pkg::seq_flags_type            flags,
   output      oal_pkg::rsp_meta_type             res_meta,
   output      logic [WORD_WIDTH-1:0]             res_word,
   output      logic                              rd_en,
   output      logic [$clog2(DEPTH)-1:0]          rd_addr,
   input  wire logic [WORD_WIDTH-1:0]             rd_data,
   output      logic                              wr_en,
   output      logic [$clog2(DEPTH)-1:0]          wr_addr,
   output      logic [WORD_WIDTH-1:0]             wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > oal_pkg::POSITION_W) ? CW : oal_pkg::POSITION_W;

   oal_pkg::seq_state_type          state_ff, state_in;
   oal_pkg::action_type             act_ff, act_in;
   oal_pkg::status_type             status_ff, status_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   pos_ff, pos_in;
   logic [CW-1:0]                   end_ff, end_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [WORD_WIDTH-1:0]           word_ff, word_in;
   logic                            pend_ff, pend_in;
   logic [AW-1:0]                   pend_addr_ff, pend_addr_in;
   logic [WORD_WIDTH-1:0]           res_word_ff, res_word_in;
   logic [oal_pkg::FOUND_W-1:0]     found_ff, found_in;

   logic [PW-1:0] pos_ext;
   logic [PW-1:0] count_ext;
   logic          down;
   logic          more;

   assign pos_ext   = PW'(req_position);
   assign count_ext = PW'(count_ff);
   assign down      = (act_ff == oal_pkg::ACT_INSERT) || (act_ff == oal_pkg::ACT_APPEND);
   assign more      = down ? (idx_ff > end_ff) : (idx_ff < end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oal_pkg::SEQ_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      idx_ff       <= idx_in;
      word_ff      <= word_in;
      pend_addr_ff <= pend_addr_in;
      res_word_ff  <= res_word_in;
      found_ff     <= found_in;
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      res_word_in  = res_word_ff;
      found_in     = found_ff;
      rd_en        = 1'b0;
      rd_addr      = down ? AW'(idx_ff - 1'b1) : AW'(idx_ff);
      wr_en        = 1'b0;
      wr_addr      = AW'(pos_ff);
      wr_data      = word_ff;

      unique case (state_ff)
         oal_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               act_in      = oal_pkg::action_type'(req_action);
               word_in     = req_word;
               res_word_in = '0;
               found_in    = '0;
               status_in   = oal_pkg::STAT_OK;
               state_in    = oal_pkg::SEQ_RUN;
               case (oal_pkg::action_type'(req_action))
                  oal_pkg::ACT_INSERT: begin
                     if (pos_ext > count_ext) begin
                        status_in = oal_pkg::STAT_BAD_INDEX;
                        state_in  = oal_pkg::SEQ_HOLD;
                     end else if (count_ff == CW'(DEPTH)) begin
                        status_in = oal_pkg::STAT_FULL;
                        state_in  = oal_pkg::SEQ_HOLD;
                     end
                     pos_in = CW'(req_position);
                     idx_in = count_ff;
                     end_in = CW'(req_position);
                  end
                  oal_pkg::ACT_APPEND: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = oal_pkg::STAT_FULL;
                        state_in  = oal_pkg::SEQ_HOLD;
                     end
                     pos_in = count_ff;
                     idx_in = count_ff;
                     end_in = count_ff;
                  end
                  oal_pkg::ACT_DELETE, oal_pkg::ACT_READ: begin
                     if (pos_ext >= count_ext) begin
                        status_in = oal_pkg::STAT_BAD_INDEX;
                        state_in  = oal_pkg::SEQ_HOLD;
                     end
                     pos_in = CW'(req_position);
                     idx_in = CW'(req_position);
                     end_in = (oal_pkg::action_type'(req_action) == oal_pkg::ACT_READ) ?
                              CW'(req_position) + 1'b1 : count_ff;
                  end
                  oal_pkg::ACT_FIND: begin
                     pos_in = '0;
                     idx_in = '0;
                     end_in = count_ff;
                  end
                  default: begin
                     state_in = oal_pkg::SEQ_HOLD;
                  end
               endcase
            end
         end

         oal_pkg::SEQ_RUN: begin
            // Issue the next read of the walk.
            rd_en        = more;
            pend_in      = more;
            pend_addr_in = rd_addr;
            idx_in       = down ? idx_ff - 1'b1 : idx_ff + 1'b1;
            if (!more) begin
               idx_in = idx_ff;
            end

            // Retire the word read in the previous cycle.
            if (pend_ff) begin
               case (act_ff)
                  oal_pkg::ACT_INSERT, oal_pkg::ACT_APPEND: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_addr_ff + 1'b1;
                     wr_data = rd_data;
                  end
                  oal_pkg::ACT_DELETE: begin
                     if (pend_addr_ff == AW'(pos_ff)) begin
                        res_word_in = rd_data;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pend_addr_ff - 1'b1;
                        wr_data = rd_data;
                     end
                  end
                  oal_pkg::ACT_READ: begin
                     res_word_in = rd_data;
                  end
                  default: begin
                     if (rd_data == word_ff) begin
                        found_in  = oal_pkg::FOUND_W'(pend_addr_ff);
                        status_in = oal_pkg::STAT_OK;
                        state_in  = oal_pkg::SEQ_HOLD;
                        pend_in   = 1'b0;
                     end
                  end
               endcase
            end

            // Walk finished: the last write-back has retired.
            if (!more && !pend_ff) begin
               state_in = oal_pkg::SEQ_HOLD;
               case (act_ff)
                  oal_pkg::ACT_INSERT, oal_pkg::ACT_APPEND: begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(pos_ff);
                     wr_data  = word_ff;
                     count_in = count_ff + 1'b1;
                  end
                  oal_pkg::ACT_DELETE: begin
                     count_in = count_ff - 1'b1;
                  end
                  oal_pkg::ACT_FIND: begin
                     status_in = oal_pkg::STAT_NOT_FOUND;
                  end
                  default: begin
                  end
               endcase
            end
         end

         oal_pkg::SEQ_HOLD: begin
            if (slot_free) begin
               state_in = oal_pkg::SEQ_IDLE;
            end
         end

         default: begin
            state_in = oal_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign flags.idle           = (state_ff == oal_pkg::SEQ_IDLE);
   assign flags.hold           = (state_ff == oal_pkg::SEQ_HOLD);
   assign res_meta.status      = status_ff;
   assign res_meta.found_at    = found_ff;
   assign res_meta.list_length = oal_pkg::LENGTH_W'(count_ff);
   assign res_word             = res_word_ff;

endmodule

`default_nettype wire

FILE: src/ordered_array_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                     Word carried
// -------   ---------  ----------------------------------------  -------------------------
// req       in         req_valid, req_stall, req_action,          one list request
//                      req_position, req_word_in
// rsp       out        rsp_valid, rsp_stall, rsp_status,          one result per request
//                      rsp_word_out, rsp_found_at, rsp_list_length
//
// Steps: a request is taken while the sequencer is idle. An insert, append,
// delete, read or find then works the list memory; a request rejected for
// a bad index or a full list, or one with an unused action code, skips the
// walk. Each request then hands its result to the output register. The
// walk is paced by the single read port of the list memory, whose
// registered data feeds one write-back per cycle.
// Reset is synchronous and active high; it empties the list. Memory contents
// are not cleared, as an entry is only read after it has been written.
// A stalled result sits in the output register while the next request is
// accepted and worked; the finished result of that one waits in the
// sequencer until the output register frees up.
module ordered_array_list_engine_unit #(
   parameter int DEPTH      = oal_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [oal_pkg::ACTION_W-1:0]       req_action,
   input  wire logic [oal_pkg::POSITION_W-1:0]     req_position,
   input  wire logic [oal_pkg::IO_WORD_W-1:0]      req_word_in,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [oal_pkg::STATUS_W-1:0]       rsp_status,
   output      logic [oal_pkg::IO_WORD_W-1:0]      rsp_word_out,
   output      logic [oal_pkg::FOUND_W-1:0]        rsp_found_at,
   output      logic [oal_pkg::LENGTH_W-1:0]       rsp_list_length
);

   localparam int AW = $clog2(DEPTH);

   oal_pkg::seq_flags_type          flags;
   oal_pkg::rsp_meta_type           res_meta;
   logic [WORD_WIDTH-1:0]           res_word;
   logic [WORD_WIDTH-1:0]           req_word;
   logic                            slot_free;
   logic                            load;

   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;
   logic [WORD_WIDTH-1:0]           rd_data;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [WORD_WIDTH-1:0]           wr_data;

   logic                            rsp_valid_ff, rsp_valid_in;
   oal_pkg::rsp_meta_type           rsp_meta_ff;
   logic [oal_pkg::IO_WORD_W-1:0]   rsp_word_ff;

   // Only the low WORD_WIDTH bits of an incoming word take part.
   assign req_word  = WORD_WIDTH'(req_word_in);
   assign req_stall = !flags.idle;

   // The output register takes a new word when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load      = flags.hold && slot_free;

   oal_seq #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_action   (req_action),
      .req_position (req_position),
      .req_word     (req_word),
      .slot_free    (slot_free),
      .flags        (flags),
      .res_meta     (res_meta),
      .res_word     (res_word),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   oal_store #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_meta_ff <= res_meta;
         rsp_word_ff <= oal_pkg::IO_WORD_W'(res_word);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_meta_ff.status;
   assign rsp_word_out    = rsp_word_ff;
   assign rsp_found_at    = rsp_meta_ff.found_at;
   assign rsp_list_length = rsp_meta_ff.list_length;

   // The walk never reads the entry it writes back in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("memory read and write hit the same entry");

   // Memory traffic only happens while a request is being worked.
   a_mem_idle: assert property (@(posedge clock) disable iff (reset)
      (flags.idle || flags.hold) |-> (!rd_en && !wr_en))
      else $error("memory access outside a walk");

   // A result handed over shows up on the output in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid && (rsp_list_length == $past(res_meta.list_length))))
      else $error("result not registered at the output");

   // A full report only comes from a full list.
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == oal_pkg::STAT_FULL)) |->
      (rsp_list_length == oal_pkg::LENGTH_W'(DEPTH)))
      else $error("full reported on a list that is not full");

endmodule

`default_nettype wire

FILE: bench/oal_list_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the list engine. It keeps a shadow copy of the
// list, predicts the result of every accepted request word and compares each
// accepted result word with the oldest prediction.
module oal_list_checker #(
   parameter int DEPTH      = oal_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [oal_pkg::ACTION_W-1:0]       req_action,
   input  logic [oal_pkg::POSITION_W-1:0]     req_position,
   input  logic [oal_pkg::IO_WORD_W-1:0]      req_word_in,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [oal_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [oal_pkg::IO_WORD_W-1:0]      rsp_word_out,
   input  logic [oal_pkg::FOUND_W-1:0]        rsp_found_at,
   input  logic [oal_pkg::LENGTH_W-1:0]       rsp_list_length,
   output int                                 failures,
   output int                                 answers_waiting,
   output int                                 list_entries
);

   typedef struct {
      oal_pkg::status_type            status;
      logic [oal_pkg::IO_WORD_W-1:0]  word_out;
      logic [oal_pkg::FOUND_W-1:0]    found_at;
      logic [oal_pkg::LENGTH_W-1:0]   list_length;
   } list_answer_type;

   logic [WORD_WIDTH-1:0] shadow_list [DEPTH];
   int unsigned           shadow_count = 0;
   list_answer_type       answers_due [$];
   list_answer_type       due_answer;
   int                    mismatch_count = 0;
   int                    results_seen = 0;

   assign failures = mismatch_count;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t ns: result %0d: %s", $time, results_seen, what);
      end
   endtask

   // Moves the tail of the list up one place and drops the word into the gap.
   function automatic void open_slot(input int unsigned slot,
                                     input logic [WORD_WIDTH-1:0] value);
      int unsigned j;
      for (j = shadow_count; j > slot; j--) begin
         shadow_list[j] = shadow_list[j - 1];
      end
      shadow_list[slot] = value;
      shadow_count++;
   endfunction

   function automatic list_answer_type apply_request(
      input logic [oal_pkg::ACTION_W-1:0]   action,
      input logic [oal_pkg::POSITION_W-1:0] position,
      input logic [oal_pkg::IO_WORD_W-1:0]  word);
      list_answer_type       ans;
      logic [WORD_WIDTH-1:0] value;
      int unsigned           slot;
      int unsigned           j;
      ans.status   = oal_pkg::STAT_OK;
      ans.word_out = '0;
      ans.found_at = '0;
      value        = WORD_WIDTH'(word);
      slot         = 32'(position);
      case (action)
         oal_pkg::ACT_INSERT: begin
            // A position past the end is checked before a full list.
            if (slot > shadow_count) begin
               ans.status = oal_pkg::STAT_BAD_INDEX;
            end else if (shadow_count >= DEPTH) begin
               ans.status = oal_pkg::STAT_FULL;
            end else begin
               open_slot(slot, value);
            end
         end
         oal_pkg::ACT_APPEND: begin
            if (shadow_count >= DEPTH) begin
               ans.status = oal_pkg::STAT_FULL;
            end else begin
               open_slot(shadow_count, value);
            end
         end
         oal_pkg::ACT_DELETE: begin
            if (slot >= shadow_count) begin
               ans.status = oal_pkg::STAT_BAD_INDEX;
            end else begin
               ans.word_out = oal_pkg::IO_WORD_W'(shadow_list[slot]);
               for (j = slot; j + 1 < shadow_count; j++) begin
                  shadow_list[j] = shadow_list[j + 1];
               end
               shadow_count--;
            end
         end
         oal_pkg::ACT_READ: begin
            if (slot >= shadow_count) begin
               ans.status = oal_pkg::STAT_BAD_INDEX;
            end else begin
               ans.word_out = oal_pkg::IO_WORD_W'(shadow_list[slot]);
            end
         end
         oal_pkg::ACT_FIND: begin
            ans.status = oal_pkg::STAT_NOT_FOUND;
            for (j = 0; j < shadow_count; j++) begin
               if (shadow_list[j] == value) begin
                  ans.status   = oal_pkg::STAT_OK;
                  ans.found_at = oal_pkg::FOUND_W'(j);
                  break;
               end
            end
         end
         default: begin
            // Unused action codes leave the list alone.
         end
      endcase
      ans.list_length = oal_pkg::LENGTH_W'(shadow_count);
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         answers_due.delete();
      end else begin
         // Results are matched before the new request is predicted, so a
         // result can never pair with a request taken in the same cycle.
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result, status %0d length %0d",
                                         rsp_status, rsp_list_length));
            end else begin
               due_answer = answers_due.pop_front();
               if (rsp_status !== due_answer.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, due_answer.status));
               end
               if (rsp_word_out !== due_answer.word_out) begin
                  report_mismatch($sformatf("word_out %h, expected %h",
                                            rsp_word_out, due_answer.word_out));
               end
               if (rsp_found_at !== due_answer.found_at) begin
                  report_mismatch($sformatf("found_at %0d, expected %0d",
                                            rsp_found_at, due_answer.found_at));
               end
               if (rsp_list_length !== due_answer.list_length) begin
                  report_mismatch($sformatf("list_length %0d, expected %0d",
                                            rsp_list_length, due_answer.list_length));
               end
            end
            results_seen++;
         end
         if (req_valid && !req_stall) begin
            answers_due.push_back(apply_request(req_action, req_position, req_word_in));
         end
      end
      answers_waiting <= answers_due.size();
      list_entries    <= shadow_count;
   end

endmodule

FILE: bench/ordered_array_list_engine_unit_tb.sv
`timescale 1ns / 1ps

// Top of the list engine bench. This module only makes stimulus and gives
// the verdict; the checker beside the block predicts and compares every
// result word.
module ordered_array_list_engine_unit_tb;

   localparam int LIST_DEPTH = oal_pkg::DEPTH_DEF;

   // How long the receiver refuses results in the pressure phase.
   localparam int LONG_HOLD_CYCLES = 400;

   // The action field has three codes beyond the defined ones.
   localparam logic [oal_pkg::ACTION_W-1:0] FIRST_UNUSED_ACTION = 3'd5;
   localparam logic [oal_pkg::ACTION_W-1:0] LAST_UNUSED_ACTION  = 3'd7;

   // Shapes of the random request stream.
   typedef enum {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_kind_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [oal_pkg::ACTION_W-1:0]     req_action = '0;
   logic [oal_pkg::POSITION_W-1:0]   req_position = '0;
   logic [oal_pkg::IO_WORD_W-1:0]    req_word_in = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [oal_pkg::STATUS_W-1:0]     rsp_status;
   logic [oal_pkg::IO_WORD_W-1:0]    rsp_word_out;
   logic [oal_pkg::FOUND_W-1:0]      rsp_found_at;
   logic [oal_pkg::LENGTH_W-1:0]     rsp_list_length;

   int failures;
   int answers_waiting;
   int list_entries;

   // Idling controls. The stimulus process sets the rates and the hold request; the receiver keeps the rest.
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit long_hold_req = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_left = 0;

   int send_idle_table [4] = '{0, 80, 0, 23};
   int stall_table [4]     = '{0, 0, 80, 23};

   always #2 clock = ~clock;

   ordered_array_list_engine_unit dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_action,
      .req_position,
      .req_word_in,
      .rsp_valid,
      .rsp_stall,
      .rsp_status,
      .rsp_word_out,
      .rsp_found_at,
      .rsp_list_length
   );

   oal_list_checker #(
      .DEPTH      (LIST_DEPTH),
      .WORD_WIDTH (oal_pkg::WORD_WIDTH_DEF)
   ) list_check (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_action,
      .req_position,
      .req_word_in,
      .rsp_valid,
      .rsp_stall,
      .rsp_status,
      .rsp_word_out,
      .rsp_found_at,
      .rsp_list_length,
      .failures,
      .answers_waiting,
      .list_entries
   );

   // Receiver. Normally it stalls at random at the rate of the current phase.
   // Once, when asked, it refuses every result word for a long stretch that
   // it counts itself, so that the engine backs up and stalls its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
         rsp_stall      <= 1'b1;
         hold_left      <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offers one request word and returns at the edge where it is taken. The
   // sender may idle first; valid is never lowered once the word is offered,
   // and the payload holds steady while the engine stalls.
   task automatic send_request(input logic [oal_pkg::ACTION_W-1:0] action,
                               input logic [oal_pkg::POSITION_W-1:0] position,
                               input logic [oal_pkg::IO_WORD_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= action;
      req_position <= position;
      req_word_in  <= word;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Stops offering words and waits until every result word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_waiting != 0) begin
         @(posedge clock);
      end
   endtask

   // Most words come from a small pool so that finds hit often; the rest are
   // fully random or sit at the extremes.
   function automatic logic [oal_pkg::IO_WORD_W-1:0] random_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) begin
         return oal_pkg::IO_WORD_W'($urandom_range(15));
      end else if (roll < 85) begin
         return $urandom;
      end
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   // One random request. Positions mostly fall inside the list as the checker
   // last saw it, which may trail the engine by one word; a few land anywhere
   // in the field to provoke bad indexes.
   task automatic send_random(input mix_kind_type mix);
      int                             roll;
      int                             len;
      int                             wild_pct;
      logic [oal_pkg::ACTION_W-1:0]   action;
      logic [oal_pkg::POSITION_W-1:0] position;
      len      = list_entries;
      roll     = $urandom_range(99);
      wild_pct = 4;
      case (mix)
         MIX_GROW: begin
            if (roll < 60)      action = oal_pkg::ACT_INSERT;
            else if (roll < 95) action = oal_pkg::ACT_APPEND;
            else                action = oal_pkg::ACT_FIND;
         end
         MIX_SHRINK: begin
            if (roll < 85)      action = oal_pkg::ACT_DELETE;
            else if (roll < 93) action = oal_pkg::ACT_READ;
            else                action = oal_pkg::ACT_FIND;
         end
         default: begin
            wild_pct = 8;
            if (roll < 20)      action = oal_pkg::ACT_INSERT;
            else if (roll < 35) action = oal_pkg::ACT_APPEND;
            else if (roll < 55) action = oal_pkg::ACT_DELETE;
            else if (roll < 75) action = oal_pkg::ACT_READ;
            else if (roll < 95) action = oal_pkg::ACT_FIND;
            else action = oal_pkg::ACTION_W'($urandom_range(FIRST_UNUSED_ACTION,
                                                           LAST_UNUSED_ACTION));
         end
      endcase
      if ($urandom_range(99) < wild_pct) begin
         position = oal_pkg::POSITION_W'($urandom_range(127));
      end else if (action == oal_pkg::ACT_INSERT) begin
         position = oal_pkg::POSITION_W'($urandom_range(len));
      end else if (len == 0) begin
         position = '0;
      end else begin
         position = oal_pkg::POSITION_W'($urandom_range(len - 1));
      end
      send_request(action, position, random_word());
   endtask

   // Grows the list until it is full, then tries to add three more words:
   // an append, an insert at a legal place and an insert past the end, which
   // must report a bad index rather than a full list.
   task automatic fill_list();
      int guard;
      guard = 0;
      while (list_entries < LIST_DEPTH && guard < 3 * LIST_DEPTH) begin
         send_random(MIX_GROW);
         guard++;
      end
      send_request(oal_pkg::ACT_APPEND, '0, random_word());
      send_request(oal_pkg::ACT_INSERT, oal_pkg::POSITION_W'($urandom_range(LIST_DEPTH)),
                   random_word());
      send_request(oal_pkg::ACT_INSERT,
                   oal_pkg::POSITION_W'($urandom_range(LIST_DEPTH + 1, 127)),
                   random_word());
   endtask

   // Deletes until the list is empty, then probes the empty list.
   task automatic empty_list();
      int guard;
      guard = 0;
      while (list_entries != 0 && guard < 3 * LIST_DEPTH) begin
         send_random(MIX_SHRINK);
         guard++;
      end
      send_request(oal_pkg::ACT_DELETE, '0, random_word());
      send_request(oal_pkg::ACT_READ, '0, random_word());
      send_request(oal_pkg::ACT_FIND, '0, random_word());
   endtask

   initial begin
      int mode;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: the empty list, both ends of the list, words at
      // the extremes, every action and the unused action codes.
      send_request(oal_pkg::ACT_READ,   7'd0,   32'h0000_0000);
      send_request(oal_pkg::ACT_DELETE, 7'd0,   32'h0000_0000);
      send_request(oal_pkg::ACT_FIND,   7'd0,   32'h0000_0000);
      send_request(oal_pkg::ACT_INSERT, 7'd1,   32'h1111_1111);
      send_request(oal_pkg::ACT_INSERT, 7'd127, 32'h2222_2222);
      send_request(oal_pkg::ACT_APPEND, 7'd0,   32'hFFFF_FFFF);
      send_request(oal_pkg::ACT_INSERT, 7'd0,   32'h0000_0000);
      send_request(oal_pkg::ACT_INSERT, 7'd1,   32'hA5A5_5A5A);
      send_request(oal_pkg::ACT_INSERT, 7'd3,   32'h1234_5678);
      send_request(oal_pkg::ACT_READ,   7'd0,   32'hFFFF_FFFF);
      send_request(oal_pkg::ACT_READ,   7'd3,   32'h0000_0000);
      send_request(oal_pkg::ACT_READ,   7'd4,   32'h0000_0000);
      send_request(oal_pkg::ACT_READ,   7'd64,  32'h0000_0000);
      send_request(oal_pkg::ACT_FIND,   7'd127, 32'hFFFF_FFFF);
      send_request(oal_pkg::ACT_FIND,   7'd0,   32'h0000_0000);
      send_request(oal_pkg::ACT_FIND,   7'd0,   32'hDEAD_BEEF);
      send_request(FIRST_UNUSED_ACTION,         7'd127, 32'hFFFF_FFFF);
      send_request(FIRST_UNUSED_ACTION + 3'd1,  7'd64,  32'h5555_5555);
      send_request(LAST_UNUSED_ACTION,          7'd1,   32'hAAAA_AAAA);
      send_request(oal_pkg::ACT_DELETE, 7'd1,   32'h0000_0000);
      send_request(oal_pkg::ACT_DELETE, 7'd3,   32'h0000_0000);
      send_request(oal_pkg::ACT_DELETE, 7'd2,   32'h0000_0000);
      send_request(oal_pkg::ACT_DELETE, 7'd0,   32'h0000_0000);
      send_request(oal_pkg::ACT_APPEND, 7'd127, 32'h5555_5555);
      send_request(oal_pkg::ACT_INSERT, 7'd0,   32'hAAAA_AAAA);
      drain_results();

      // Pressure: the receiver holds off for a long stretch while the sender
      // keeps offering words, so the engine backs up and stalls its input.
      // The sender then pauses until every result word has come back.
      long_hold_req <= 1'b1;
      repeat (24) send_random(MIX_CHURN);
      drain_results();

      // Random phases, one per idling setting: fill the list to the top,
      // work it while nearly full, empty it, then work it while short.
      for (mode = 0; mode < 4; mode++) begin
         send_idle_pct <= send_idle_table[mode];
         stall_pct     <= stall_table[mode];
         fill_list();
         for (n = 0; n < 35; n++) send_random(MIX_CHURN);
         empty_list();
         for (n = 0; n < 20; n++) send_random(MIX_CHURN);
         drain_results();
      end

      // Let the receiver take everything, then give a stray result time to
      // show up before the verdict.
      stall_pct <= 0;
      drain_results();
      repeat (2 * LIST_DEPTH + 16) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
